// File: hdl/rtr_pkg.sv
`default_nettype none

package rtr_pkg;

  typedef struct packed {
    logic        func;
    logic [31:0] now_us;
  } in_t;

  typedef struct packed {
    logic        edge_accepted;
    logic [31:0] rpm;
    logic [31:0] distance_total;
  } out_t;

  localparam logic [1:0] RegReedEnabled     = 2'd0;
  localparam logic [1:0] RegBeltStepDistance = 2'd1;
  localparam logic [1:0] RegMinGapUs        = 2'd2;
  localparam logic [1:0] RegStallLimitUs    = 2'd3;

  localparam logic        FuncEdge = 1'b0;
  localparam logic        FuncRead = 1'b1;

  localparam logic        ReedEnabledReset   = 1'b1;
  localparam logic [15:0] BeltStepReset      = 16'd0;
  localparam logic [15:0] MinGapReset        = 16'd300;
  localparam logic [31:0] StallLimitReset    = 32'd1000000;
  localparam logic [31:0] RpmNumerator       = 32'd60000000;
  localparam logic [31:0] RpmSaturated       = 32'hFFFF_FFFF;
  localparam logic [15:0] RevCountMax        = 16'hFFFF;

endpackage

`default_nettype wire

// File: hdl/reed_tachometer_rpm.sv
// channel | dir | handshake             | beat
// in      | in  | in_valid_i/in_ready_o | rtr_pkg::in_t  (func, now_us)
// out     | out | out_valid_o/out_ready_i | rtr_pkg::out_t (edge_accepted, rpm, distance_total)
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// an edge beat runs a bit-serial pass (gap subtract, three compares, two adds),
// then a commit state and a result state; a read beat runs up to two 32-step
// restoring divisions on one shared divider; a read with no revolutions or sensor
// disabled goes straight to the result state; one beat is in work at a time; the
// output register lets the next beat in while a result waits; reset is asynchronous,
// clears counters and control state and sets config registers to reset values
`default_nettype none

module reed_tachometer_rpm (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rtr_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rtr_pkg::out_t      out_data_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StEdge = 3'd1;
  localparam logic [2:0] StEfin = 3'd2;
  localparam logic [2:0] StDiv1 = 3'd3;
  localparam logic [2:0] StDmid = 3'd4;
  localparam logic [2:0] StDiv2 = 3'd5;
  localparam logic [2:0] StDfin = 3'd6;
  localparam logic [2:0] StDone = 3'd7;

  logic [2:0]  state_q;
  logic [4:0]  bit_q;

  logic        reed_en_q;
  logic [15:0] belt_step_q;
  logic [15:0] min_gap_q;
  logic [31:0] stall_q;

  logic [31:0] start_q;
  logic [31:0] last_period_q;
  logic [31:0] sum_q;
  logic [15:0] rev_q;
  logic [31:0] dist_q;

  logic [31:0] now_q;
  logic [31:0] gap_q;
  logic [31:0] nsum_q;
  logic [31:0] ndist_q;
  logic        borrow_q, lt_q, gts_q, gth_q, csum_q, cdist_q;

  logic [31:0] num_q;
  logic [31:0] rem_q;
  logic [31:0] dvs_q;

  logic        res_acc_q;
  logic [31:0] res_rpm_q;

  logic        out_valid_q;
  rtr_pkg::out_t out_q;

  logic        in_fire;
  logic [31:0] min_ext, half_lp, step_ext;
  logic        nb, sb, mb, stb, hb, ob, db, g;
  logic        borrow_d, lt_d, gts_d, gth_d, csum_d, cdist_d;
  logic [32:0] rem_sh;
  logic [33:0] diff;
  logic        qbit;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // bit-serial edge datapath, lsb first
  assign min_ext  = {16'd0, min_gap_q};
  assign half_lp  = {1'b0, last_period_q[31:1]};
  assign step_ext = {16'd0, belt_step_q};

  always_comb begin
    nb = now_q[bit_q];
    sb = start_q[bit_q];
    mb = min_ext[bit_q];
    stb = stall_q[bit_q];
    hb = half_lp[bit_q];
    ob = sum_q[bit_q];
    db = dist_q[bit_q];
    g = nb ^ sb ^ borrow_q;
    borrow_d = (~nb & sb) | (~(nb ^ sb) & borrow_q);
    lt_d  = (~g & mb) | (~(g ^ mb) & lt_q);
    gts_d = (g & ~stb) | (~(g ^ stb) & gts_q);
    gth_d = (g & ~hb) | (~(g ^ hb) & gth_q);
    csum_d  = (ob & g) | (ob & csum_q) | (g & csum_q);
    cdist_d = (db & step_ext[bit_q]) | (db & cdist_q) | (step_ext[bit_q] & cdist_q);
  end

  // shared restoring divider step
  always_comb begin
    rem_sh = {rem_q, num_q[31]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    qbit   = ~diff[33];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reed_en_q   <= rtr_pkg::ReedEnabledReset;
      belt_step_q <= rtr_pkg::BeltStepReset;
      min_gap_q   <= rtr_pkg::MinGapReset;
      stall_q     <= rtr_pkg::StallLimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rtr_pkg::RegReedEnabled:      reed_en_q   <= cfg_data_i[0];
        rtr_pkg::RegBeltStepDistance: belt_step_q <= cfg_data_i[15:0];
        rtr_pkg::RegMinGapUs:         min_gap_q   <= cfg_data_i[15:0];
        rtr_pkg::RegStallLimitUs:     stall_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      bit_q         <= '0;
      start_q       <= '0;
      last_period_q <= '0;
      sum_q         <= '0;
      rev_q         <= '0;
      dist_q        <= '0;
      out_valid_q   <= 1'b0;
      borrow_q      <= 1'b0;
      lt_q          <= 1'b0;
      gts_q         <= 1'b0;
      gth_q         <= 1'b0;
      csum_q        <= 1'b0;
      cdist_q       <= 1'b0;
      res_acc_q     <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            bit_q     <= '0;
            res_acc_q <= 1'b0;
            res_rpm_q <= '0;
            if (in_data_i.func == rtr_pkg::FuncEdge) begin
              now_q    <= in_data_i.now_us;
              borrow_q <= 1'b0;
              lt_q     <= 1'b0;
              gts_q    <= 1'b0;
              gth_q    <= 1'b0;
              csum_q   <= 1'b0;
              cdist_q  <= 1'b0;
              state_q  <= StEdge;
            end else if (reed_en_q && (rev_q != 16'd0)) begin
              num_q   <= sum_q;
              dvs_q   <= {16'd0, rev_q};
              rem_q   <= '0;
              state_q <= StDiv1;
            end else begin
              state_q <= StDone;
            end
          end
        end
        StEdge: begin
          borrow_q <= borrow_d;
          lt_q     <= lt_d;
          gts_q    <= gts_d;
          gth_q    <= gth_d;
          csum_q   <= csum_d;
          cdist_q  <= cdist_d;
          gap_q    <= {g, gap_q[31:1]};
          nsum_q   <= {ob ^ g ^ csum_q, nsum_q[31:1]};
          ndist_q  <= {db ^ step_ext[bit_q] ^ cdist_q, ndist_q[31:1]};
          bit_q    <= bit_q + 5'd1;
          if (bit_q == 5'd31) begin
            state_q <= StEfin;
          end
        end
        StEfin: begin
          if (!lt_q) begin
            if (gts_q) begin
              start_q       <= now_q;
              last_period_q <= '0;
            end else if (gth_q) begin
              start_q       <= now_q;
              last_period_q <= gap_q;
              if (rev_q != rtr_pkg::RevCountMax) begin
                rev_q <= rev_q + 16'd1;
              end
              sum_q     <= csum_q ? rtr_pkg::RpmSaturated : nsum_q;
              dist_q    <= ndist_q;
              res_acc_q <= 1'b1;
            end
          end
          state_q <= StDone;
        end
        StDiv1, StDiv2: begin
          num_q <= {num_q[30:0], qbit};
          rem_q <= qbit ? diff[31:0] : rem_sh[31:0];
          bit_q <= bit_q + 5'd1;
          if (bit_q == 5'd31) begin
            state_q <= (state_q == StDiv1) ? StDmid : StDfin;
          end
        end
        StDmid: begin
          if (num_q == 32'd0) begin
            res_rpm_q <= rtr_pkg::RpmSaturated;
            rev_q     <= '0;
            sum_q     <= '0;
            state_q   <= StDone;
          end else begin
            dvs_q   <= num_q;
            num_q   <= rtr_pkg::RpmNumerator;
            rem_q   <= '0;
            bit_q   <= '0;
            state_q <= StDiv2;
          end
        end
        StDfin: begin
          res_rpm_q <= num_q;
          rev_q     <= '0;
          sum_q     <= '0;
          state_q   <= StDone;
        end
        StDone: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.edge_accepted  <= res_acc_q;
            out_q.rpm            <= res_rpm_q;
            out_q.distance_total <= dist_q;
            out_valid_q          <= 1'b1;
            state_q              <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/rtr_checker.sv
`default_nettype none

module rtr_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire rtr_pkg::out_t out_data_o,
  input wire logic          cfg_valid_i,
  input wire logic          cfg_ready_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // one beat in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a beat is in work");

  // an edge result never carries rpm
  a_edge_no_rpm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.edge_accepted |-> out_data_o.rpm == 32'd0)
    else $error("accepted edge with nonzero rpm");

  // config port never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write stalled");

endmodule

bind reed_tachometer_rpm rtr_checker u_rtr_checker (.*);

`default_nettype wire

// File: sim/rpm_checker.sv
module rpm_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  rtr_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  rtr_pkg::out_t out_data_i,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  output int            fail_count_o,
  output int            pending_o
);

  logic        sensor_on;
  logic [15:0] step_dist;
  logic [15:0] bounce_gap;
  logic [31:0] stall_gap;

  logic [31:0] rev_origin;
  logic [31:0] prev_period;
  logic [31:0] period_sum;
  logic [15:0] rev_tally;
  logic [31:0] belt_dist;

  rtr_pkg::out_t pending_readings[$];
  int            readings_seen;

  initial fail_count_o = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("checker: result %0d %s got %h want %h", readings_seen, what, got, want);
    fail_count_o++;
  endtask

  task automatic advance_tach(input rtr_pkg::in_t beat, output rtr_pkg::out_t res);
    logic [31:0] gap;
    logic [31:0] avg;
    res = '0;
    if (beat.func == rtr_pkg::FuncEdge) begin
      gap = beat.now_us - rev_origin;
      if (gap >= {16'd0, bounce_gap}) begin
        if (gap > stall_gap) begin
          rev_origin  = beat.now_us;
          prev_period = '0;
        end else if (gap > (prev_period >> 1)) begin
          rev_origin  = beat.now_us;
          prev_period = gap;
          if (rev_tally != rtr_pkg::RevCountMax) rev_tally = rev_tally + 16'd1;
          if (period_sum > rtr_pkg::RpmSaturated - gap) period_sum = rtr_pkg::RpmSaturated;
          else period_sum = period_sum + gap;
          belt_dist = belt_dist + {16'd0, step_dist};
          res.edge_accepted = 1'b1;
        end
      end
    end else if (sensor_on && rev_tally != '0) begin
      avg = period_sum / {16'd0, rev_tally};
      res.rpm = (avg == '0) ? rtr_pkg::RpmSaturated : rtr_pkg::RpmNumerator / avg;
      rev_tally  = '0;
      period_sum = '0;
    end
    res.distance_total = belt_dist;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rtr_pkg::out_t want;
    if (!rst_ni) begin
      sensor_on   = rtr_pkg::ReedEnabledReset;
      step_dist   = rtr_pkg::BeltStepReset;
      bounce_gap  = rtr_pkg::MinGapReset;
      stall_gap   = rtr_pkg::StallLimitReset;
      rev_origin  = '0;
      prev_period = '0;
      period_sum  = '0;
      rev_tally   = '0;
      belt_dist   = '0;
      readings_seen = 0;
      pending_readings.delete();
      pending_o <= 0;
    end else begin
      // result side first: a beat taken at this edge cannot be answered yet
      if (out_valid_i && out_ready_i) begin
        if (pending_readings.size() == 0) begin
          report("with nothing expected, rpm", out_data_i.rpm, '0);
        end else begin
          want = pending_readings.pop_front();
          if (out_data_i.edge_accepted !== want.edge_accepted)
            report("edge_accepted", {31'd0, out_data_i.edge_accepted},
                   {31'd0, want.edge_accepted});
          if (out_data_i.rpm !== want.rpm)
            report("rpm", out_data_i.rpm, want.rpm);
          if (out_data_i.distance_total !== want.distance_total)
            report("distance_total", out_data_i.distance_total, want.distance_total);
        end
        readings_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        advance_tach(in_data_i, want);
        pending_readings.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          rtr_pkg::RegReedEnabled:      sensor_on  = cfg_data_i[0];
          rtr_pkg::RegBeltStepDistance: step_dist  = cfg_data_i[15:0];
          rtr_pkg::RegMinGapUs:         bounce_gap = cfg_data_i[15:0];
          rtr_pkg::RegStallLimitUs:     stall_gap  = cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= pending_readings.size();
    end
  end

endmodule

// File: sim/testbench.sv
module testbench;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  rtr_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  rtr_pkg::out_t out_data_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i = rtr_pkg::RegReedEnabled;
  logic [31:0]   cfg_data_i = '0;

  int          fail_count;
  int          pending;
  logic        calm = 1'b0;

  logic [15:0] min_gap_cfg = rtr_pkg::MinGapReset;
  logic [31:0] stall_cfg = rtr_pkg::StallLimitReset;
  int          n_beats = 0;
  int          n_reads = 0;
  int          n_settings = 0;

  reed_tachometer_rpm dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  rpm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_beat(input logic func, input logic [31:0] now);
    if (!calm) begin
      while ($urandom_range(0, 99) < 34) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{func: func, now_us: now};
    do @(posedge clk_i); while (!in_ready_o);
    n_beats++;
    if (func == rtr_pkg::FuncRead) n_reads++;
  endtask

  // hold the sender until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic cfg_beat(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic write_settings(input logic reed, input logic [15:0] belt,
                                input logic [15:0] gap, input logic [31:0] stall);
    drain();
    cfg_beat(rtr_pkg::RegReedEnabled, {31'd0, reed});
    cfg_beat(rtr_pkg::RegBeltStepDistance, {16'd0, belt});
    cfg_beat(rtr_pkg::RegMinGapUs, {16'd0, gap});
    cfg_beat(rtr_pkg::RegStallLimitUs, stall);
    cfg_valid_i <= 1'b0;
    min_gap_cfg = gap;
    stall_cfg   = stall;
    n_settings++;
  endtask

  initial begin
    logic [31:0] t;
    logic [31:0] period;
    logic [15:0] mg;
    logic [31:0] st;
    int          r;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_settings(1'b1, 16'd7, rtr_pkg::MinGapReset, rtr_pkg::StallLimitReset);
    send_beat(rtr_pkg::FuncRead, 32'hFFFF_FFFF);
    send_beat(rtr_pkg::FuncEdge, 32'd0);
    send_beat(rtr_pkg::FuncEdge, 32'd1000);
    send_beat(rtr_pkg::FuncEdge, 32'd1100);
    send_beat(rtr_pkg::FuncEdge, 32'd1400);
    send_beat(rtr_pkg::FuncEdge, 32'd2400);
    send_beat(rtr_pkg::FuncEdge, 32'd1002401);
    send_beat(rtr_pkg::FuncEdge, 32'd1007401);
    send_beat(rtr_pkg::FuncRead, 32'd0);
    send_beat(rtr_pkg::FuncRead, 32'd0);
    // timestamp wrap around zero
    send_beat(rtr_pkg::FuncEdge, 32'hFFFF_FF00);
    t = 32'h0000_1000;
    send_beat(rtr_pkg::FuncEdge, t);
    t = t + rtr_pkg::StallLimitReset;
    send_beat(rtr_pkg::FuncEdge, t);

    write_settings(1'b0, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
    send_beat(rtr_pkg::FuncEdge, t);
    send_beat(rtr_pkg::FuncRead, 32'h5555_AAAA);
    write_settings(1'b1, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
    send_beat(rtr_pkg::FuncRead, 32'hAAAA_5555);
    // interval sum saturation
    t = t + 32'hF000_0000;
    send_beat(rtr_pkg::FuncEdge, t);
    t = t + 32'hF000_0000;
    send_beat(rtr_pkg::FuncEdge, t);
    send_beat(rtr_pkg::FuncRead, t);

    write_settings(1'b1, 16'hFFFF, 16'd0, 32'd0);
    t = t + 32'd1;
    send_beat(rtr_pkg::FuncEdge, t);
    write_settings(1'b1, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
    t = t + 32'd1;
    send_beat(rtr_pkg::FuncEdge, t);
    t = t + 32'd1;
    send_beat(rtr_pkg::FuncEdge, t);
    send_beat(rtr_pkg::FuncRead, t);

    write_settings(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    t = t + 32'd65534;
    send_beat(rtr_pkg::FuncEdge, t);
    t = t + 32'd1;
    send_beat(rtr_pkg::FuncEdge, t);
    send_beat(rtr_pkg::FuncRead, t);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: write_settings(1'b1, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
        1: write_settings(1'b0, 16'd0, 16'hFFFF, 32'd0);
        default: begin
          mg = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 1000))
                                           : 16'($urandom_range(0, 65535));
          case ($urandom_range(0, 2))
            0:       st = rtr_pkg::StallLimitReset;
            1:       st = $urandom_range(mg, 2000000);
            default: st = $urandom;
          endcase
          write_settings($urandom_range(0, 3) != 0, 16'($urandom_range(0, 65535)), mg, st);
        end
      endcase
      calm <= (p == 3);
      period = $urandom_range(600, 300000);
      if (period <= {16'd0, min_gap_cfg}) period = min_gap_cfg + $urandom_range(1, 50000);
      t = $urandom;
      for (int i = 0; i < 100; i++) begin
        if (p == 5 && i == 50) drain();
        r = $urandom_range(0, 99);
        if (r < 15) begin
          send_beat(rtr_pkg::FuncRead, $urandom);
        end else begin
          if (r < 65) t = t + period - period / 8 + $urandom_range(0, period / 4);
          else if (r < 75) t = t + $urandom_range(0, min_gap_cfg);
          else if (r < 83) t = t + $urandom_range(1, period / 2);
          else if (r < 90) t = t + stall_cfg + $urandom_range(1, 1000);
          else if (r < 95) t = $urandom;
          else t = t + $urandom_range(0, 3);
          send_beat(rtr_pkg::FuncEdge, t);
        end
      end
    end

    drain();
    calm <= 1'b0;
    repeat (100) @(posedge clk_i);
    $display("run: %0d beats, %0d of them reads, under %0d register settings", n_beats,
             n_reads, n_settings);
    $display("run: bounce, stall, wrap and saturation cases plus random belt traffic");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
